### hw/rtl/cht_pkg.sv
// Shared types and constants for the chained hash table.
// Holds the field widths, default sizing, status and operation codes and the sequencer states.
// No dependencies.
package cht_pkg;

	// Field widths of the request and response transactions
	localparam int CHT_KEY_BITS        = 31;
	localparam int CHT_VALUE_WORD_BITS = 32;
	localparam int CHT_STATUS_BITS     = 3;

	// Default table sizing
	localparam int CHT_NUM_BUCKETS      = 16;
	localparam int CHT_SLOTS_PER_BUCKET = 8;
	localparam int CHT_VALUE_BITS       = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} cht_op_t;

	typedef enum logic [CHT_STATUS_BITS-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_REPLACED  = 3'd1,
		STAT_REMOVED   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} cht_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_SCAN,
		ST_WRITE
	} cht_state_t;

endpackage

### hw/rtl/cht_if.sv
// Valid/ready channels of the chained hash table: request and response.
// Depends on cht_pkg for the field widths.

interface cht_req_if import cht_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [CHT_KEY_BITS-1:0]        key;
	logic [CHT_VALUE_WORD_BITS-1:0] value_word;

	modport source (output valid, output operation, output key, output value_word, input ready);
	modport sink   (input valid, input operation, input key, input value_word, output ready);
endinterface

interface cht_rsp_if import cht_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CHT_STATUS_BITS-1:0] status;
	logic                       table_empty;

	modport source (output valid, output status, output table_empty, input ready);
	modport sink   (input valid, input status, input table_empty, output ready);
endinterface

### hw/rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/cht_mod.sv
// Bucket index unit: key modulo the bucket count.
// A power-of-two count is a registered mask of the low key bits; any other count takes
// a reciprocal multiply stage then a subtract correction stage. Depends on cht_pkg.
module cht_mod import cht_pkg::*; #(
	parameter int NUM_BUCKETS = CHT_NUM_BUCKETS,
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CHT_KEY_BITS-1:0] key,
	output logic                    done,
	output logic [BW-1:0]           bucket
);

	localparam bit POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
	localparam bit ONE  = NUM_BUCKETS == 1;

	generate
		if (POW2) begin : g_mask
			logic          done_q;
			logic [BW-1:0] bucket_q;

			// Flag the result in the cycle after start
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			// Keep the low key bits
			always_ff @(posedge clk) begin
				if (start) begin
					bucket_q <= ONE ? '0 : key[BW-1:0];
				end
			end

			assign done   = done_q;
			assign bucket = bucket_q;
		end else begin : g_recip
			// Quotient is (key * RECIP) >> SH, exact for every 31-bit key
			localparam int          SH    = CHT_KEY_BITS + BW;
			localparam int          PW    = CHT_KEY_BITS + 32;
			localparam logic [63:0] RECIP =
				((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
			localparam logic [CHT_KEY_BITS-1:0] NB_K = CHT_KEY_BITS'(NUM_BUCKETS);

			logic                    mul_vld_q;
			logic                    done_q;
			logic [CHT_KEY_BITS-1:0] key_q;
			logic [PW-1:0]           prod_q;
			logic [BW-1:0]           rem_q;
			logic [CHT_KEY_BITS-1:0] quot;
			logic [CHT_KEY_BITS-1:0] rem_full;

			// Take the quotient from the product and subtract its multiple of the count
			always_comb begin
				quot     = CHT_KEY_BITS'(prod_q >> SH);
				rem_full = key_q - quot * NB_K;
			end

			// Multiply stage then correction stage
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mul_vld_q <= 1'b0;
					done_q    <= 1'b0;
				end else begin
					mul_vld_q <= start;
					done_q    <= mul_vld_q;
				end
			end

			// Product and remainder
			always_ff @(posedge clk) begin
				if (start) begin
					key_q  <= key;
					prod_q <= PW'(key) * PW'(RECIP[31:0]);
				end
				if (mul_vld_q) begin
					rem_q <= rem_full[BW-1:0];
				end
			end

			assign done   = done_q;
			assign bucket = rem_q;
		end
	endgenerate

endmodule

### hw/rtl/chained_hash_table.sv
// Key-value table with NUM_BUCKETS buckets of SLOTS_PER_BUCKET slots; a key lives in bucket
// key mod NUM_BUCKETS. A request inserts (or updates) or removes one key and returns one
// response with a status and a table-empty flag. One request is in work at a time and req.ready
// is low meanwhile; a finished response waits in an output register while the next request is
// taken. A request goes through an accept step, the bucket index (a mask for a power-of-two bucket
// count, otherwise a reciprocal multiply then a subtract correction), a scan of the bucket through
// the key memory's single registered read port (one slot per cycle, stopping early on a key match)
// and a write-back step, which waits while an earlier response is still untaken. After reset the
// block runs a clearing pass over the valid bits of all NUM_BUCKETS * SLOTS_PER_BUCKET slots
// before it takes its first request.
// Depends on cht_pkg, cht_if, cht_ram and cht_mod.
module chained_hash_table import cht_pkg::*; #(
	parameter int NUM_BUCKETS      = CHT_NUM_BUCKETS,
	parameter int SLOTS_PER_BUCKET = CHT_SLOTS_PER_BUCKET,
	parameter int VALUE_BITS       = CHT_VALUE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	cht_req_if.sink   req,
	cht_rsp_if.source rsp
);

	localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int CW    = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int NW    = $clog2(TOTAL + 1);
	localparam int MW    = AW + CW;
	localparam int KW    = CHT_KEY_BITS;

	cht_state_t state_q, state_d;

	// Control registers
	logic [AW-1:0] clr_addr_q;
	logic [CW-1:0] rd_idx_q;
	logic          cmp_vld_q;
	logic [CW-1:0] cmp_idx_q;
	logic          hit_q;
	logic [CW-1:0] hit_idx_q;
	logic          free_q;
	logic [CW-1:0] free_idx_q;
	logic [NW-1:0] count_q, count_d;
	logic          out_vld_q;

	// Payload registers
	cht_op_t         op_q;
	logic [KW-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]   base_q;
	cht_status_t     out_status_q, status_d;
	logic            out_empty_q;

	// Memory ports and unit handshake
	logic          key_we, key_re, val_we;
	logic [AW-1:0] key_wa, key_ra, wr_addr;
	logic [KW:0]   key_wd, key_rd;
	logic          mod_start, mod_done;
	logic [BW-1:0] mod_bucket;

	logic          req_ready;
	logic          out_load;
	logic          can_out;
	logic          cmp_match, cmp_free, scan_last, rd_more;
	logic [CW-1:0] wr_idx;

	// Key memory: valid bit on top of the key
	cht_ram #(
		.WIDTH (KW + 1),
		.DEPTH (TOTAL)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (key_wa),
		.wr_data (key_wd),
		.rd_en   (key_re),
		.rd_addr (key_ra),
		.rd_data (key_rd)
	);

	// Value memory: written only, values are kept with their keys
	cht_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TOTAL)
	) u_val_ram (
		.clk     (clk),
		.wr_en   (val_we),
		.wr_addr (wr_addr),
		.wr_data (val_q),
		.rd_en   (1'b0),
		.rd_addr ('0),
		.rd_data ()
	);

	cht_mod #(
		.NUM_BUCKETS (NUM_BUCKETS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (req.key),
		.done   (mod_done),
		.bucket (mod_bucket)
	);

	// Compare the slot returned by the key memory
	always_comb begin
		cmp_match = cmp_vld_q && key_rd[KW] && (key_rd[KW-1:0] == key_q);
		cmp_free  = cmp_vld_q && !key_rd[KW];
		scan_last = cmp_vld_q && (cmp_idx_q == CW'(SLOTS_PER_BUCKET - 1));
		rd_more   = rd_idx_q != CW'(SLOTS_PER_BUCKET);
		can_out   = !out_vld_q || rsp.ready;
		wr_idx    = hit_q ? hit_idx_q : free_idx_q;
		wr_addr   = base_q + AW'(wr_idx);
	end

	// Next state, memory ports and result
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		mod_start = 1'b0;
		key_we    = 1'b0;
		key_wa    = wr_addr;
		key_wd    = {1'b1, key_q};
		key_re    = 1'b0;
		key_ra    = base_q + AW'(rd_idx_q);
		val_we    = 1'b0;
		status_d  = STAT_FULL;
		count_d   = count_q;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				key_we = 1'b1;
				key_wa = clr_addr_q;
				key_wd = '0;
				if (clr_addr_q == AW'(TOTAL - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					mod_start = 1'b1;
					state_d   = ST_HASH;
				end
			end
			ST_HASH: begin
				if (mod_done) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				key_re = rd_more;
				if (cmp_match || scan_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (op_q == OP_INSERT) begin
					if (hit_q) begin
						status_d = STAT_REPLACED;
						val_we   = can_out;
					end else if (free_q) begin
						status_d = STAT_INSERTED;
						key_we   = can_out;
						val_we   = can_out;
						count_d  = count_q + NW'(1);
					end else begin
						status_d = STAT_FULL;
					end
				end else begin
					if (hit_q) begin
						status_d = STAT_REMOVED;
						key_we   = can_out;
						key_wd   = {1'b0, key_q};
						count_d  = count_q - NW'(1);
					end else begin
						status_d = STAT_NOT_FOUND;
					end
				end
				if (can_out) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Sequencer and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			rd_idx_q   <= '0;
			cmp_vld_q  <= 1'b0;
			cmp_idx_q  <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			count_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (state_q == ST_HASH) begin
				rd_idx_q  <= '0;
				cmp_vld_q <= 1'b0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (rd_more) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				cmp_vld_q <= rd_more;
				cmp_idx_q <= rd_idx_q;
				if (cmp_match) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cmp_idx_q;
				end
				if (cmp_free && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= cmp_idx_q;
				end
			end
			if (out_load) begin
				count_q   <= count_d;
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Capture the request, bucket base and response
	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			op_q  <= cht_op_t'(req.operation);
			key_q <= req.key;
			val_q <= VALUE_BITS'(req.value_word);
		end
		if (state_q == ST_HASH && mod_done) begin
			base_q <= AW'(MW'(mod_bucket) * MW'(SLOTS_PER_BUCKET));
		end
		if (out_load) begin
			out_status_q <= status_d;
			out_empty_q  <= count_d == '0;
		end
	end

	assign req.ready       = req_ready;
	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.table_empty = out_empty_q;

	// A transaction moves the sequencer on to bucket indexing
	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_HASH))
		else $error("accepted request did not start bucket indexing");

	// A response appears only out of the write-back step
	a_rsp_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_WRITE))
		else $error("response raised outside write-back");

	// The empty flag on a pending response matches the entry count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.table_empty == (count_q == '0)))
		else $error("table_empty disagrees with entry count");

	// The entry count never exceeds the slot count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(TOTAL))
		else $error("entry count above slot count");

endmodule
